/* src/pipt_pkg.sv */
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared constants and types of the point-in-path winding test.
// ----------------------------------------------------------------------------
package pipt_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int WIND_WIDTH_DEF  = 16;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X   = 2'd0,
    REG_QUERY_Y   = 2'd1,
    REG_FILL_RULE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FILL_NONZERO  = 1'b0,
    FILL_EVEN_ODD = 1'b1
  } fill_rule_t;

  // outcome of one edge against the query ray
  typedef struct packed {
    logic hit;  // edge crosses the ray right of the point
    logic up;   // upward crossing
  } edge_hit_t;

endpackage

/* src/pipt_if.sv */
// ----------------------------------------------------------------------------
// pipt_vertex_if / pipt_result_if
// Valid/ready channels for vertex and result transactions.
// ----------------------------------------------------------------------------
interface pipt_vertex_if import pipt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          end_of_contour;
  logic                          end_of_path;

  modport source (output valid, vertex_x, vertex_y, end_of_contour, end_of_path,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, end_of_contour, end_of_path,
                  output ready);
endinterface

interface pipt_result_if import pipt_pkg::*; #(
  parameter int WIND_WIDTH = WIND_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         inside_res;
  logic signed [WIND_WIDTH-1:0] winding_total;
  logic                         odd_crossings;

  modport source (output valid, inside_res, winding_total, odd_crossings,
                  input ready);
  modport sink   (input valid, inside_res, winding_total, odd_crossings,
                  output ready);
endinterface

/* src/pipt_edge.sv */
// ----------------------------------------------------------------------------
// pipt_edge
// Tests one edge a->b against the ray from the query point toward +x, using
// an exact cross-multiplied sign test.
// ----------------------------------------------------------------------------
module pipt_edge import pipt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  output edge_hit_t                     result
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, qx_e, qy_e;
  logic signed [DW-1:0] dy, ax_qx, qy_ay, bx_ax;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [SW-1:0] sum;
  logic                 up_cond, dn_cond, sum_pos, sum_neg;

  assign ax_e = {ax[COORD_WIDTH-1], ax};
  assign ay_e = {ay[COORD_WIDTH-1], ay};
  assign bx_e = {bx[COORD_WIDTH-1], bx};
  assign by_e = {by[COORD_WIDTH-1], by};
  assign qx_e = {qx[COORD_WIDTH-1], qx};
  assign qy_e = {qy[COORD_WIDTH-1], qy};

  assign dy    = by_e - ay_e;
  assign ax_qx = ax_e - qx_e;
  assign qy_ay = qy_e - ay_e;
  assign bx_ax = bx_e - ax_e;

  assign prod_a = ax_qx * dy;
  assign prod_b = qy_ay * bx_ax;
  assign sum    = {prod_a[PW-1], prod_a} + {prod_b[PW-1], prod_b};

  assign sum_neg = sum[SW-1];
  assign sum_pos = !sum[SW-1] && (sum != '0);

  // horizontal edges fail both conditions
  assign up_cond = (ay <= qy) && (by > qy);
  assign dn_cond = (by <= qy) && (ay > qy);

  assign result.hit = (up_cond && sum_pos) || (dn_cond && sum_neg);
  assign result.up  = up_cond;

endmodule

/* src/point_in_path_winding_test_top.sv */
// The final vertex of a path reaches its result transaction through the input
// register, the previous-edge and closing-edge tests (cross-multiplied) and the result register.
// Throughput: one vertex per cycle, but a final vertex waits on an untaken result.
// Reset (synchronous, rst high) clears the contour state, accumulators,
// query registers and fill rule; the block is ready the cycle after.
// ----------------------------------------------------------------------------
// point_in_path_winding_test_top
// Streams path vertices, counts ray crossings per edge and reports inside or
// outside under the nonzero or even-odd rule at the end of each path.
// ----------------------------------------------------------------------------
module point_in_path_winding_test_top import pipt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int WIND_WIDTH  = WIND_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  pipt_vertex_if.sink            vtx,
  pipt_result_if.source          res
);

  localparam logic signed [WIND_WIDTH-1:0] WMAX = {1'b0, {(WIND_WIDTH-1){1'b1}}};
  localparam logic signed [WIND_WIDTH-1:0] WMIN = {1'b1, {(WIND_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] query_x, query_y;
  fill_rule_t                    fill_rule;

  logic                          s1_valid;
  logic signed [COORD_WIDTH-1:0] s1_x, s1_y;
  logic                          s1_eoc, s1_eop;
  logic                          s1_fire, vtx_fire;

  logic signed [COORD_WIDTH-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [COORD_WIDTH-1:0] first_sel_x, first_sel_y;
  logic                          in_contour;
  logic signed [WIND_WIDTH-1:0]  winding_acc, wind_mid, wind_end;
  logic                          parity_acc, par_end;
  logic                          closing;
  edge_hit_t                     hit_prev, hit_close;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x   <= '0;
      query_y   <= '0;
      fill_rule <= FILL_NONZERO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUERY_X:   query_x   <= cfg_data;
        REG_QUERY_Y:   query_y   <= cfg_data;
        REG_FILL_RULE: fill_rule <= fill_rule_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // input register
  assign s1_fire   = s1_valid && (!s1_eop || !res.valid || res.ready);
  assign vtx.ready = !s1_valid || s1_fire;
  assign vtx_fire  = vtx.valid && vtx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (vtx.ready) begin
      s1_valid <= vtx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vtx_fire) begin
      s1_x   <= vtx.vertex_x;
      s1_y   <= vtx.vertex_y;
      s1_eoc <= vtx.end_of_contour;
      s1_eop <= vtx.end_of_path;
    end
  end

  // edge tests
  assign first_sel_x = in_contour ? first_x : s1_x;
  assign first_sel_y = in_contour ? first_y : s1_y;
  assign closing     = s1_eoc || s1_eop;

  pipt_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_prev (
    .ax(prev_x), .ay(prev_y), .bx(s1_x), .by(s1_y),
    .qx(query_x), .qy(query_y), .result(hit_prev)
  );

  pipt_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
    .ax(s1_x), .ay(s1_y), .bx(first_sel_x), .by(first_sel_y),
    .qx(query_x), .qy(query_y), .result(hit_close)
  );

  // saturating winding update, one step per edge
  always_comb begin
    wind_mid = winding_acc;
    if (in_contour && hit_prev.hit) begin
      if (hit_prev.up && (winding_acc != WMAX)) begin
        wind_mid = winding_acc + 1'b1;
      end else if (!hit_prev.up && (winding_acc != WMIN)) begin
        wind_mid = winding_acc - 1'b1;
      end
    end
    wind_end = wind_mid;
    if (closing && hit_close.hit) begin
      if (hit_close.up && (wind_mid != WMAX)) begin
        wind_end = wind_mid + 1'b1;
      end else if (!hit_close.up && (wind_mid != WMIN)) begin
        wind_end = wind_mid - 1'b1;
      end
    end
    par_end = parity_acc ^ (in_contour && hit_prev.hit) ^ (closing && hit_close.hit);
  end

  // contour state and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      first_x     <= '0;
      first_y     <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      in_contour  <= 1'b0;
      winding_acc <= '0;
      parity_acc  <= 1'b0;
    end else if (s1_fire) begin
      first_x     <= first_sel_x;
      first_y     <= first_sel_y;
      prev_x      <= s1_x;
      prev_y      <= s1_y;
      in_contour  <= !closing;
      winding_acc <= s1_eop ? '0 : wind_end;
      parity_acc  <= s1_eop ? 1'b0 : par_end;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_fire && s1_eop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_eop) begin
      res.inside_res    <= (fill_rule == FILL_EVEN_ODD) ? par_end : (wind_end != '0);
      res.winding_total <= wind_end;
      res.odd_crossings <= par_end;
    end
  end

`ifndef SYNTH
  a_clear_on_path_end: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_eop |=> (winding_acc == '0) && !parity_acc && !in_contour)
    else $error("accumulators not cleared after path end");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_x) && $stable(s1_y))
    else $error("held vertex lost while stalled");

  a_ready_only_blocked_by_item: assert property (@(posedge clk) disable iff (rst)
    !vtx.ready |-> s1_valid && s1_eop && res.valid)
    else $error("input blocked without a pending result");
`endif

endmodule

/* bench/pipt_winding_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pipt_winding_monitor
// Watches the configuration port and both vertex and result channels, keeps
// its own contour state and winding/parity counts, and compares every result
// transaction against the predicted verdict for its path.
// ----------------------------------------------------------------------------
module pipt_winding_monitor import pipt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int WIND_WIDTH  = WIND_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          vtx_valid,
  input  logic                          vtx_ready,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic                          end_of_contour,
  input  logic                          end_of_path,
  input  logic                          res_valid,
  input  logic                          res_ready,
  input  logic                          inside_res,
  input  logic signed [WIND_WIDTH-1:0]  winding_total,
  input  logic                          odd_crossings,
  output int                            fail_count,
  output int                            pending
);

  localparam longint WIND_MAX = (longint'(1) << (WIND_WIDTH - 1)) - 1;
  localparam longint WIND_MIN = -WIND_MAX - 1;
  localparam int     SHOWN    = 10;

  typedef struct packed {
    logic                         covered;
    logic signed [WIND_WIDTH-1:0] winding;
    logic                         odd;
  } path_verdict_t;

  path_verdict_t                 verdict_q[$];
  logic signed [COORD_WIDTH-1:0] cfg_signed;
  longint                        qx, qy;
  fill_rule_t                    rule;
  longint                        first_x, first_y, prev_x, prev_y;
  logic                          in_contour;
  longint                        winding;
  logic                          parity;
  int                            mismatches = 0;
  int                            depth = 0;

  assign cfg_signed = cfg_data;
  assign fail_count = mismatches;
  assign pending    = depth;

  // exact side test of the row crossing against the query x, no division
  function automatic edge_hit_t probe_edge(longint ax, longint ay, longint bx, longint by);
    edge_hit_t h;
    longint    side;
    h = '0;
    if (ay == by) return h;
    if (ay <= qy && by > qy) h.up = 1'b1;
    else if (!(by <= qy && ay > qy)) return h;
    side  = (ax - qx) * (by - ay) + (qy - ay) * (bx - ax);
    h.hit = h.up ? (side > 0) : (side < 0);
    return h;
  endfunction

  function automatic void tally(edge_hit_t h);
    if (h.hit) begin
      parity = ~parity;
      if (h.up) begin
        if (winding < WIND_MAX) winding++;
      end else if (winding > WIND_MIN) begin
        winding--;
      end
    end
  endfunction

  function automatic void absorb_vertex(longint vx, longint vy, logic eoc, logic eop);
    path_verdict_t v;
    if (!in_contour) begin
      first_x    = vx;
      first_y    = vy;
      in_contour = 1'b1;
    end else begin
      tally(probe_edge(prev_x, prev_y, vx, vy));
    end
    prev_x = vx;
    prev_y = vy;
    if (eoc || eop) begin
      tally(probe_edge(vx, vy, first_x, first_y));
      in_contour = 1'b0;
    end
    if (eop) begin
      v.covered = (rule == FILL_EVEN_ODD) ? parity : (winding != 0);
      v.winding = winding[WIND_WIDTH-1:0];
      v.odd     = parity;
      verdict_q = {verdict_q, v};
      winding = 0;
      parity  = 1'b0;
    end
  endfunction

  function automatic void note_failure(string what);
    mismatches++;
    if (mismatches <= SHOWN) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    path_verdict_t want, got;
    if (rst) begin
      qx         = 0;
      qy         = 0;
      rule       = FILL_NONZERO;
      first_x    = 0;
      first_y    = 0;
      prev_x     = 0;
      prev_y     = 0;
      in_contour = 1'b0;
      winding    = 0;
      parity     = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_QUERY_X:   qx = cfg_signed;
          REG_QUERY_Y:   qy = cfg_signed;
          REG_FILL_RULE: rule = fill_rule_t'(cfg_data[0]);
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        got.covered = inside_res;
        got.winding = winding_total;
        got.odd     = odd_crossings;
        if (verdict_q.size() == 0) begin
          note_failure($sformatf("unexpected result inside=%0b winding=%0d odd=%0b",
                                 got.covered, got.winding, got.odd));
        end else begin
          want = verdict_q.pop_front();
          if (got.covered !== want.covered || got.winding !== want.winding ||
              got.odd !== want.odd) begin
            note_failure($sformatf(
              "expected inside=%0b winding=%0d odd=%0b, got inside=%0b winding=%0d odd=%0b",
              want.covered, want.winding, want.odd, got.covered, got.winding, got.odd));
          end
        end
      end
      if (vtx_valid && vtx_ready)
        absorb_vertex(vertex_x, vertex_y, end_of_contour, end_of_path);
    end
    depth = verdict_q.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives vertex transactions (directed paths, random paths around the query
// point, multi-loop paths) under several query/fill-rule settings,
// with random sender bursts and receiver stalls; the monitor checks results.
// ----------------------------------------------------------------------------
module testbench;
  import pipt_pkg::*;

  localparam int CW             = COORD_WIDTH_DEF;
  localparam int WW             = WIND_WIDTH_DEF;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int RANDOM_PHASES  = 8;
  localparam int WIND_LOOPS     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] WIND_SPAN = 256;

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_LONG} stall_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]        cfg_data;
  int                   fail_count;
  int                   pending;

  int                   cur_qx, cur_qy;
  int                   burst_left = 0;
  int                   items_sent = 0;
  bit                   steady_feed = 1'b0;
  int                   idle_cycles = 0;
  logic [5:0]           sink_cycle = '0;
  stall_mode_t          sink_mode = SINK_OPEN;

  pipt_vertex_if #(.COORD_WIDTH(CW)) vtx ();
  pipt_result_if #(.WIND_WIDTH(WW))  res ();

  point_in_path_winding_test_top #(.COORD_WIDTH(CW), .WIND_WIDTH(WW)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx       (vtx),
    .res       (res)
  );

  pipt_winding_monitor #(.COORD_WIDTH(CW), .WIND_WIDTH(WW)) monitor_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .vtx_valid      (vtx.valid),
    .vtx_ready      (vtx.ready),
    .vertex_x       (vtx.vertex_x),
    .vertex_y       (vtx.vertex_y),
    .end_of_contour (vtx.end_of_contour),
    .end_of_path    (vtx.end_of_path),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .inside_res     (res.inside_res),
    .winding_total  (res.winding_total),
    .odd_crossings  (res.odd_crossings),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stall pattern, mode picked anew each time the 6-bit sink_cycle wraps
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1'b1;
    if (sink_cycle == '0) sink_mode <= stall_mode_t'($urandom_range(0, 3));
    case (sink_mode)
      SINK_OPEN:     res.ready <= 1'b1;
      SINK_RANDOM:   res.ready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: res.ready <= (sink_cycle[2:0] < 3'd5);
      default:       res.ready <= (sink_cycle[4:0] >= 5'd12);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic eoc, input logic eop);
    int gap;
    if (!steady_feed && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        vtx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    vtx.valid          <= 1'b1;
    vtx.vertex_x       <= x;
    vtx.vertex_y       <= y;
    vtx.end_of_contour <= eoc;
    vtx.end_of_path    <= eop;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic configure(input logic signed [CW-1:0] qx, input logic signed [CW-1:0] qy,
                           input fill_rule_t rule);
    cfg_we    <= 1'b1;
    cfg_index <= REG_QUERY_X;
    cfg_data  <= qx;
    @(posedge clk);
    cfg_index <= REG_QUERY_Y;
    cfg_data  <= qy;
    @(posedge clk);
    cfg_index <= REG_FILL_RULE;
    cfg_data  <= CW'(rule);
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= CW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_qx = qx;
    cur_qy = qy;
  endtask

  // wait until every expected result has come, then let the pipeline drain
  task automatic settle();
    vtx.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] near_coord(int q, int reach);
    int     pick;
    longint v;
    pick = $urandom_range(0, 99);
    if (pick < 10) return CW'($urandom);
    if (pick < 18) return CW'(q);
    if (pick < 22) return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
    v = longint'(q) + longint'($urandom_range(0, 2 * reach)) - reach;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return CW'(v);
  endfunction

  task automatic send_path();
    int   contours, count, reach;
    bit   scramble;
    logic eoc, eop;
    case ($urandom_range(0, 4))
      0:       reach = 2;
      1:       reach = 6;
      2:       reach = 256;
      3:       reach = 4096;
      default: reach = 1 << 20;
    endcase
    contours = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    scramble = ($urandom_range(0, 9) == 0);
    for (int c = 0; c < contours; c++) begin
      case ($urandom_range(0, 9))
        0:       count = 1;
        1:       count = 2;
        default: count = $urandom_range(3, 8);
      endcase
      for (int k = 0; k < count; k++) begin
        if (scramble) begin
          eoc = ($urandom_range(0, 3) == 0);
          eop = ($urandom_range(0, 9) == 0);
        end else begin
          eop = (k == count - 1) && (c == contours - 1);
          eoc = (k == count - 1) && !(eop && $urandom_range(0, 1) == 0);
        end
        send_vertex(near_coord(cur_qx, reach), near_coord(cur_qy, reach), eoc, eop);
      end
    end
  endtask

  // one contour looping WIND_LOOPS times around the origin, up or down
  task automatic wind_around(input bit upward);
    logic last;
    steady_feed = 1'b1;
    for (int k = 0; k < WIND_LOOPS; k++) begin
      last = (k == WIND_LOOPS - 1);
      send_vertex(-WIND_SPAN, -WIND_SPAN, 1'b0, 1'b0);
      if (upward) begin
        send_vertex(WIND_SPAN, -WIND_SPAN, 1'b0, 1'b0);
        send_vertex(0, WIND_SPAN, last, last);
      end else begin
        send_vertex(0, WIND_SPAN, 1'b0, 1'b0);
        send_vertex(WIND_SPAN, -WIND_SPAN, last, last);
      end
    end
    steady_feed = 1'b0;
  endtask

  initial begin
    logic signed [CW-1:0] qx, qy;
    fill_rule_t           rule;
    int                   target;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_QUERY_X;
    cfg_data           <= '0;
    vtx.valid          <= 1'b0;
    vtx.vertex_x       <= '0;
    vtx.vertex_y       <= '0;
    vtx.end_of_contour <= 1'b0;
    vtx.end_of_path    <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(0, 0, FILL_NONZERO);
    // lone vertex path
    send_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b1);
    // two-vertex contour, then a triangle around the point
    send_vertex(256, -256, 1'b0, 1'b0);
    send_vertex(256, 256, 1'b1, 1'b0);
    send_vertex(-256, -256, 1'b0, 1'b0);
    send_vertex(256, -256, 1'b0, 1'b0);
    send_vertex(0, 256, 1'b1, 1'b0);
    // full-range square with horizontal edges
    send_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1, 1'b1);
    // crossing exactly at the query x
    send_vertex(-256, -256, 1'b0, 1'b0);
    send_vertex(256, 256, 1'b0, 1'b0);
    send_vertex(-256, 256, 1'b0, 1'b1);
    // vertex on the query row
    send_vertex(256, 0, 1'b0, 1'b0);
    send_vertex(256, 512, 1'b0, 1'b0);
    send_vertex(512, -512, 1'b1, 1'b1);
    // one-vertex contour followed by another
    send_vertex(-1, -1, 1'b1, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b1);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          qx   = CW'(int'($urandom_range(0, 4095)) - 2048);
          qy   = CW'(int'($urandom_range(0, 4095)) - 2048);
          rule = FILL_EVEN_ODD;
        end
        1: begin qx = COORD_MAX; qy = COORD_MIN; rule = FILL_NONZERO;  end
        2: begin qx = COORD_MIN; qy = COORD_MAX; rule = FILL_EVEN_ODD; end
        3: begin qx = COORD_MIN; qy = COORD_MIN; rule = FILL_NONZERO;  end
        4: begin qx = COORD_MAX; qy = COORD_MAX; rule = FILL_EVEN_ODD; end
        default: begin
          qx   = CW'($urandom);
          qy   = CW'($urandom);
          rule = fill_rule_t'($urandom_range(0, 1));
        end
      endcase
      configure(qx, qy, rule);
      target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < target) send_path();
      settle();
    end

    // multi-loop winding both ways
    configure(0, 0, FILL_NONZERO);
    wind_around(1'b1);
    wind_around(1'b0);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* point_in_path_winding_test_top.f */
src/pipt_pkg.sv
src/pipt_if.sv
src/pipt_edge.sv
src/point_in_path_winding_test_top.sv
bench/pipt_winding_monitor.sv
bench/testbench.sv
